// File: hw/rtl/mrb_pkg.sv
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared types and constants for the multicast ring buffer: ring geometry,
// slot limits, frame length limit, operation and status codes, entry layout.
// ----------------------------------------------------------------------------
package mrb_pkg;

  // Ring geometry.
  localparam int ENTRY_COUNT = 16;
  localparam int ENTRY_IDX_W = $clog2(ENTRY_COUNT);
  localparam int FREE_W      = $clog2(ENTRY_COUNT + 1);
  localparam int PEND_W      = $clog2(ENTRY_COUNT + 1);

  // Reader slots.
  localparam int MAX_SLOTS   = 16;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int COUNT_W     = $clog2(MAX_SLOTS + 1);
  localparam logic [COUNT_W-1:0] MIN_COUNT   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

  // Frame fields.
  localparam int HANDLE_W        = 32;
  localparam int LEN_IN_W        = 16;
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int LEN_OUT_W       = 12;
  localparam int WRITER_W        = 5;
  localparam logic [WRITER_W-1:0] GATEWAY_CODE = WRITER_W'(16);

  // Delivery flags.
  localparam logic [1:0] FLAG_COMPONENTS = 2'b01;
  localparam logic [1:0] FLAG_GATEWAY    = 2'b10;

  // Operation codes.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  // One ring entry.
  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [LEN_OUT_W-1:0] length;
    logic [WRITER_W-1:0]  writer;
    logic [1:0]           flags;
    logic [COUNT_W-1:0]   reads_owed;
  } entry_t;

endpackage

// File: hw/rtl/multicast_ring_buffer.sv
// ----------------------------------------------------------------------------
// multicast_ring_buffer
// Broadcast ring of frame handles with a read pointer per reader slot.
// Each access passes the input register, then the result register. Throughput:
// one access per cycle; each access is a single read-modify-write of one entry
// and the slot counters.
// The receiver cannot stall: done is a one-cycle strobe that nothing holds off.
// Reset (synchronous): pointers and pending counts clear, the free count returns
// to 16, the reader count returns to 2, busy is set; entries are not cleared.
// ----------------------------------------------------------------------------
module multicast_ring_buffer
  import mrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op,
  input  logic [SLOT_W-1:0]     slot_id,
  input  logic [HANDLE_W-1:0]   payload_handle,
  input  logic [LEN_IN_W-1:0]   length,
  output logic                  done,
  output logic [1:0]            status,
  output logic [HANDLE_W-1:0]   handle_out,
  output logic [LEN_OUT_W-1:0]  length_out,
  output logic [WRITER_W-1:0]   writer_out,
  output logic                  delivered,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_W-1:0]    cfg_data
);

  // Input register.
  logic                 in_valid_q;
  op_t                  op_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [LEN_IN_W-1:0]  len_q;

  // Control state.
  logic [COUNT_W-1:0]     reader_count;
  logic [ENTRY_IDX_W-1:0] write_pointer;
  logic [FREE_W-1:0]      free_entries;
  logic [FREE_W-1:0]      free_entries_next;

  // Result next values.
  status_t              status_next;
  logic [HANDLE_W-1:0]  handle_next;
  logic [LEN_OUT_W-1:0] length_next;
  logic [WRITER_W-1:0]  writer_next;
  logic                 delivered_next;

  // Entry and slot control.
  logic                   count_ok;
  logic [COUNT_W-1:0]     count_eff;
  logic                   do_write;
  logic                   do_read;
  entry_t                 wr_entry;
  entry_t                 rd_entry;
  logic [ENTRY_IDX_W-1:0] rd_idx;
  logic                   pend_zero;
  logic [LEN_OUT_W-1:0]   clip_len;
  logic                   deliver;

  // The block accepts every cycle once out of reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = !busy && !in_valid_q;

  // Reader count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      reader_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reader_count <= cfg_data;
    end
  end

  // Effective count saturates into the supported slot range.
  always_comb begin
    count_eff = reader_count;
    if (reader_count < MIN_COUNT) begin
      count_eff = MIN_COUNT;
    end else if (reader_count > COUNT_W'(MAX_SLOTS)) begin
      count_eff = COUNT_W'(MAX_SLOTS);
    end
  end

  // Input register captures the accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q     <= op_t'(op);
      slot_q   <= slot_id;
      handle_q <= payload_handle;
      len_q    <= length;
    end
  end

  // Slot pointers and pending counts.
  mrb_slot_table u_slots (
    .clk       (clk),
    .rst       (rst),
    .count     (count_eff),
    .bump      (do_write),
    .adv       (do_read),
    .slot      (slot_q),
    .ptr       (rd_idx),
    .pend_zero (pend_zero)
  );

  // Ring entries.
  mrb_entry_store u_entries (
    .clk      (clk),
    .wr_en    (do_write),
    .wr_idx   (write_pointer),
    .wr_entry (wr_entry),
    .dec_en   (do_read),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  // Access decision and result formation.
  always_comb begin
    count_ok = ({1'b0, slot_q} < count_eff) && (len_q != '0);
    clip_len = (len_q > LEN_IN_W'(MAX_FRAME_BYTES)) ? LEN_OUT_W'(MAX_FRAME_BYTES)
                                                    : len_q[LEN_OUT_W-1:0];
    deliver  = rd_entry.flags[0] || ((slot_q == '0) && rd_entry.flags[1]);

    wr_entry.handle     = handle_q;
    wr_entry.length     = clip_len;
    wr_entry.writer     = (slot_q == '0) ? GATEWAY_CODE : WRITER_W'(slot_q);
    wr_entry.flags      = (slot_q == '0) ? FLAG_COMPONENTS
                                         : (FLAG_COMPONENTS | FLAG_GATEWAY);
    wr_entry.reads_owed = count_eff;

    do_write          = 1'b0;
    do_read           = 1'b0;
    free_entries_next = free_entries;
    status_next       = ST_REFUSED;
    handle_next       = '0;
    length_next       = '0;
    writer_next       = '0;
    delivered_next    = 1'b0;

    if (in_valid_q && count_ok) begin
      unique case (op_q)
        OP_WRITE: begin
          if (free_entries == '0) begin
            status_next = ST_FULL;
          end else begin
            do_write          = 1'b1;
            free_entries_next = free_entries - FREE_W'(1);
            status_next       = ST_OK;
            length_next       = clip_len;
          end
        end
        OP_READ: begin
          if (pend_zero) begin
            status_next = ST_EMPTY;
          end else begin
            do_read        = 1'b1;
            status_next    = ST_OK;
            writer_next    = rd_entry.writer;
            delivered_next = deliver;
            if (deliver) begin
              handle_next = rd_entry.handle;
              length_next = (LEN_IN_W'(rd_entry.length) <= len_q) ? rd_entry.length
                                                                   : len_q[LEN_OUT_W-1:0];
            end
            if ((rd_entry.reads_owed <= COUNT_W'(1)) &&
                (free_entries < FREE_W'(ENTRY_COUNT))) begin
              free_entries_next = free_entries + FREE_W'(1);
            end
          end
        end
        default: begin
          status_next = ST_REFUSED;
        end
      endcase
    end
  end

  // Ring control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      free_entries  <= FREE_W'(ENTRY_COUNT);
    end else begin
      free_entries <= free_entries_next;
      if (do_write) begin
        write_pointer <= write_pointer + ENTRY_IDX_W'(1);
      end
    end
  end

  // Result register: one strobe per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_q) begin
      status     <= status_next;
      handle_out <= handle_next;
      length_out <= length_next;
      writer_out <= writer_next;
      delivered  <= delivered_next;
    end
  end

  // Every accepted word yields its result through the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted word produced no result");

  // A successful write consumes exactly one free entry.
  a_write_takes_entry: assert property (@(posedge clk) disable iff (rst)
    (do_write) |=> (free_entries == FREE_W'($past(free_entries) - FREE_W'(1))))
    else $error("free entry count not decremented on write");

  // A refused, full or empty access reports no frame.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((handle_out == '0) && !delivered &&
                                     (length_out == '0) && (writer_out == '0)))
    else $error("rejected access reported frame data");

  // The free count never exceeds the ring size.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_entries <= FREE_W'(ENTRY_COUNT))
    else $error("free entry count out of range");

endmodule

// File: hw/rtl/mrb_entry_store.sv
// ----------------------------------------------------------------------------
// mrb_entry_store
// Register file holding the ring entries: one full-entry write port, one
// read port at the reader's index, and a readers-left decrement at that index.
// ----------------------------------------------------------------------------
module mrb_entry_store
  import mrb_pkg::*;
(
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [ENTRY_IDX_W-1:0] wr_idx,
  input  entry_t                 wr_entry,
  input  logic                   dec_en,
  input  logic [ENTRY_IDX_W-1:0] rd_idx,
  output entry_t                 rd_entry
);

  entry_t entries [ENTRY_COUNT];

  // Entry contents are payload and carry no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_idx] <= wr_entry;
    end else if (dec_en && (entries[rd_idx].reads_owed != '0)) begin
      entries[rd_idx].reads_owed <= entries[rd_idx].reads_owed - COUNT_W'(1);
    end
  end

  // Read port selects the entry at the reader's pointer.
  assign rd_entry = entries[rd_idx];

endmodule

// File: hw/rtl/mrb_slot_table.sv
// ----------------------------------------------------------------------------
// mrb_slot_table
// Per-slot read pointers and pending-frame counts. A write bumps every
// registered slot; a read advances and decrements the reading slot.
// ----------------------------------------------------------------------------
module mrb_slot_table
  import mrb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [COUNT_W-1:0]     count,
  input  logic                   bump,
  input  logic                   adv,
  input  logic [SLOT_W-1:0]      slot,
  output logic [ENTRY_IDX_W-1:0] ptr,
  output logic                   pend_zero
);

  logic [ENTRY_IDX_W-1:0] rd_ptr  [MAX_SLOTS];
  logic [PEND_W-1:0]      pending [MAX_SLOTS];

  // Each slot updates on its own; the pending count saturates at the ring size.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        rd_ptr[i]  <= '0;
        pending[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (bump && (COUNT_W'(i) < count) && (pending[i] < PEND_W'(ENTRY_COUNT))) begin
          pending[i] <= pending[i] + PEND_W'(1);
        end else if (adv && (slot == SLOT_W'(i))) begin
          pending[i] <= pending[i] - PEND_W'(1);
          rd_ptr[i]  <= rd_ptr[i] + ENTRY_IDX_W'(1);
        end
      end
    end
  end

  assign ptr       = rd_ptr[slot];
  assign pend_zero = (pending[slot] == '0);

endmodule
